// ----- rtl/nbcss_pkg.sv -----
// ----------------------------------------------------------------------------
// nbcss_pkg: shared types and constants for the configuration space shadow core
// Transaction structs, request codes, register offsets, write masks and the
// power-on contents of the configuration byte store.
// ----------------------------------------------------------------------------
package nbcss_pkg;

    typedef logic [1:0] req_t;

    localparam req_t REQ_READ  = 2'd0;
    localparam req_t REQ_WRITE = 2'd1;
    localparam req_t REQ_RESET = 2'd2;

    typedef struct packed {
        req_t       req_type;
        logic [2:0] func_num;
        logic [7:0] reg_addr;
        logic [7:0] wdata;
    } in_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [9:0] read_internal;
        logic [9:0] write_internal;
        logic       shadow_bios;
        logic       remap;
    } out_t;

    localparam int unsigned CFG_DEPTH = 256;
    localparam int unsigned CFG_AW    = 8;

    // Registers held in flops (masked, write-one-to-clear or attribute bytes)
    localparam logic [7:0] ADDR_CMD    = 8'h04;
    localparam logic [7:0] ADDR_STATUS = 8'h07;
    localparam logic [7:0] ADDR_PAM1   = 8'h61;
    localparam logic [7:0] ADDR_PAM2   = 8'h62;
    localparam logic [7:0] ADDR_PAM3   = 8'h63;
    localparam logic [7:0] ADDR_CTL65  = 8'h65;
    localparam logic [7:0] ADDR_CTL66  = 8'h66;
    localparam logic [7:0] ADDR_CTL67  = 8'h67;
    localparam logic [7:0] ADDR_CTL68  = 8'h68;
    localparam logic [7:0] ADDR_CTL6D  = 8'h6D;
    localparam logic [7:0] ADDR_CTL70  = 8'h70;
    localparam logic [7:0] ADDR_CTL71  = 8'h71;
    localparam logic [7:0] ADDR_CTL73  = 8'h73;
    localparam logic [7:0] ADDR_CTL75  = 8'h75;

    localparam logic [7:0] MASK_CMD    = 8'h40;
    localparam logic [7:0] MASK_W1C    = 8'hB0;
    localparam logic [7:0] MASK_CTL65  = 8'h20;
    localparam logic [7:0] MASK_CTL66  = 8'h05;
    localparam logic [7:0] MASK_CTL67  = 8'hC0;
    localparam logic [7:0] MASK_CTL68  = 8'h40;
    localparam logic [7:0] MASK_CTL6D  = 8'h6F;
    localparam logic [7:0] MASK_CTL70  = 8'h01;
    localparam logic [7:0] MASK_CTL71  = 8'h4E;
    localparam logic [7:0] MASK_CTL73  = 8'h0C;
    localparam logic [7:0] MASK_CTL75  = 8'hC7;
    // device reset drops the F0000 attribute field
    localparam logic [7:0] MASK_F_KEEP = 8'hCF;

    localparam logic [7:0] RST_CMD     = 8'h07;
    localparam logic [7:0] RST_STATUS  = 8'h02;
    localparam logic [7:0] ABSENT_DATA = 8'hFF;

    // Power-on value of bytes kept in the RAM
    function automatic logic [7:0] reset_byte(input logic [7:0] addr);
        logic [7:0] val;
        val = 8'h00;
        case (addr) inside
            8'h00:          val = 8'h06;
            8'h01:          val = 8'h11;
            8'h02:          val = 8'h95;
            8'h03:          val = 8'h15;
            8'h06:          val = 8'hA0;
            8'h08:          val = 8'h02;
            8'h0B:          val = 8'h06;
            8'h52:          val = 8'h02;
            8'h58:          val = 8'h40;
            8'h59:          val = 8'h05;
            [8'h5A:8'h5F]:  val = 8'h01;
            8'h64:          val = 8'hAB;
            default:        val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic logic is_read_only(input logic [7:0] addr);
        logic ro;
        ro = 1'b0;
        case (addr) inside
            8'h00, 8'h01, [8'h08:8'h0C], 8'h0E, 8'h0F: ro = 1'b1;
            default:                                   ro = 1'b0;
        endcase
        return ro;
    endfunction

    function automatic logic [7:0] masked_set(input logic [7:0] old, input logic [7:0] mask,
                                              input logic [7:0] val);
        return (old & ~mask) | (val & mask);
    endfunction

endpackage

// ----- rtl/nbcss_ram.sv -----
// ----------------------------------------------------------------------------
// nbcss_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when not enabled.
// ----------------------------------------------------------------------------
module nbcss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/northbridge_config_space_shadow_ctl_core.sv -----
// ----------------------------------------------------------------------------
// northbridge_config_space_shadow_ctl_core: PCI config space with shadow control
// Function 0 configuration bytes, masked/W1C register rules and ROM segment
// shadow attributes decoded from registers 0x61..0x63.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request transaction (read, write or device reset);
//   m_ channel returns one result per request, in order.
//   State is updated on the edge that accepts a request. Plain bytes live in a
//   256x8 RAM with per-byte valid flops (unwritten bytes read their power-on
//   value); masked, W1C and attribute registers are flops.
//   Pipeline: request register + RAM read, then result register. A request
//   enters the request stage on the accepting edge and moves to the result
//   register once that is free; one transaction per cycle sustained while
//   m_ready stays high. The rate is set by the single registered RAM read port.
//   Reset (aresetn low, synchronous) restores the power-on contents at once,
//   empties the pipeline and holds s_ready low; no clearing pass is needed.
//   When m_ready stays low the result holds, one more request is taken into
//   the request stage, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module northbridge_config_space_shadow_ctl_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  nbcss_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output nbcss_pkg::out_t  m_data
);

    // flop-backed registers
    logic [7:0] cmd_reg,    cmd_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] pam1_reg,   pam1_next;
    logic [7:0] pam2_reg,   pam2_next;
    logic [7:0] pam3_reg,   pam3_next;
    logic [7:0] ctl65_reg,  ctl65_next;
    logic [7:0] ctl66_reg,  ctl66_next;
    logic [7:0] ctl67_reg,  ctl67_next;
    logic [7:0] ctl68_reg,  ctl68_next;
    logic [7:0] ctl6d_reg,  ctl6d_next;
    logic [7:0] ctl70_reg,  ctl70_next;
    logic [7:0] ctl71_reg,  ctl71_next;
    logic [7:0] ctl73_reg,  ctl73_next;
    logic [7:0] ctl75_reg,  ctl75_next;

    logic [nbcss_pkg::CFG_DEPTH-1:0] byte_valid_reg;

    logic       accept;
    logic       wr_func0;
    logic       flop_hit;
    logic [7:0] flop_rd;
    logic       mem_we;
    logic [7:0] ram_rdata;
    logic [9:0] rd_int_next;
    logic [9:0] wr_int_next;

    // request stage
    logic                         s1_valid_reg;
    nbcss_pkg::req_t              s1_req_reg;
    logic                         s1_func0_reg;
    logic                         s1_flop_hit_reg;
    logic [7:0]                   s1_flop_data_reg;
    logic                         s1_mem_valid_reg;
    logic [nbcss_pkg::CFG_AW-1:0] s1_addr_reg;
    logic [9:0]                   s1_rd_int_reg;
    logic [9:0]                   s1_wr_int_reg;
    logic                         s1_shadow_reg;
    logic                         s1_remap_reg;

    // result stage
    logic            m_valid_reg;
    nbcss_pkg::out_t m_data_reg;
    nbcss_pkg::out_t out_next;
    logic            advance;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = aresetn && (!s1_valid_reg || advance);
    assign accept  = s_valid && s_ready;
    assign wr_func0 = accept && (s_data.req_type == nbcss_pkg::REQ_WRITE)
                      && (s_data.func_num == 3'd0);

    always_comb begin
        cmd_next    = cmd_reg;
        status_next = status_reg;
        pam1_next   = pam1_reg;
        pam2_next   = pam2_reg;
        pam3_next   = pam3_reg;
        ctl65_next  = ctl65_reg;
        ctl66_next  = ctl66_reg;
        ctl67_next  = ctl67_reg;
        ctl68_next  = ctl68_reg;
        ctl6d_next  = ctl6d_reg;
        ctl70_next  = ctl70_reg;
        ctl71_next  = ctl71_reg;
        ctl73_next  = ctl73_reg;
        ctl75_next  = ctl75_reg;
        flop_hit    = 1'b1;
        flop_rd     = 8'h00;
        mem_we      = 1'b0;

        case (s_data.reg_addr)
            nbcss_pkg::ADDR_CMD:    flop_rd = cmd_reg;
            nbcss_pkg::ADDR_STATUS: flop_rd = status_reg;
            nbcss_pkg::ADDR_PAM1:   flop_rd = pam1_reg;
            nbcss_pkg::ADDR_PAM2:   flop_rd = pam2_reg;
            nbcss_pkg::ADDR_PAM3:   flop_rd = pam3_reg;
            nbcss_pkg::ADDR_CTL65:  flop_rd = ctl65_reg;
            nbcss_pkg::ADDR_CTL66:  flop_rd = ctl66_reg;
            nbcss_pkg::ADDR_CTL67:  flop_rd = ctl67_reg;
            nbcss_pkg::ADDR_CTL68:  flop_rd = ctl68_reg;
            nbcss_pkg::ADDR_CTL6D:  flop_rd = ctl6d_reg;
            nbcss_pkg::ADDR_CTL70:  flop_rd = ctl70_reg;
            nbcss_pkg::ADDR_CTL71:  flop_rd = ctl71_reg;
            nbcss_pkg::ADDR_CTL73:  flop_rd = ctl73_reg;
            nbcss_pkg::ADDR_CTL75:  flop_rd = ctl75_reg;
            default:                flop_hit = 1'b0;
        endcase

        if (wr_func0) begin
            case (s_data.reg_addr)
                nbcss_pkg::ADDR_CMD:
                    cmd_next = nbcss_pkg::masked_set(cmd_reg, nbcss_pkg::MASK_CMD, s_data.wdata);
                nbcss_pkg::ADDR_STATUS:
                    status_next = status_reg & ~(s_data.wdata & nbcss_pkg::MASK_W1C);
                nbcss_pkg::ADDR_PAM1:  pam1_next = s_data.wdata;
                nbcss_pkg::ADDR_PAM2:  pam2_next = s_data.wdata;
                nbcss_pkg::ADDR_PAM3:  pam3_next = s_data.wdata;
                nbcss_pkg::ADDR_CTL65:
                    ctl65_next = nbcss_pkg::masked_set(ctl65_reg, nbcss_pkg::MASK_CTL65,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL66:
                    ctl66_next = nbcss_pkg::masked_set(ctl66_reg, nbcss_pkg::MASK_CTL66,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL67:
                    ctl67_next = nbcss_pkg::masked_set(ctl67_reg, nbcss_pkg::MASK_CTL67,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL68:
                    ctl68_next = nbcss_pkg::masked_set(ctl68_reg, nbcss_pkg::MASK_CTL68,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL6D:
                    ctl6d_next = nbcss_pkg::masked_set(ctl6d_reg, nbcss_pkg::MASK_CTL6D,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL70:
                    ctl70_next = nbcss_pkg::masked_set(ctl70_reg, nbcss_pkg::MASK_CTL70,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL71:
                    ctl71_next = nbcss_pkg::masked_set(ctl71_reg, nbcss_pkg::MASK_CTL71,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL73:
                    ctl73_next = nbcss_pkg::masked_set(ctl73_reg, nbcss_pkg::MASK_CTL73,
                                                       s_data.wdata);
                nbcss_pkg::ADDR_CTL75:
                    ctl75_next = nbcss_pkg::masked_set(ctl75_reg, nbcss_pkg::MASK_CTL75,
                                                       s_data.wdata);
                default:
                    mem_we = !nbcss_pkg::is_read_only(s_data.reg_addr);
            endcase
        end

        if (accept && (s_data.req_type == nbcss_pkg::REQ_RESET)) begin
            pam3_next = pam3_reg & nbcss_pkg::MASK_F_KEEP;
        end
    end

    // Segment attributes after this transaction: bit 1 read to DRAM, bit 0 write
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            rd_int_next[s]     = pam1_next[2*s+1];
            wr_int_next[s]     = pam1_next[2*s];
            rd_int_next[s + 4] = pam2_next[2*s+1];
            wr_int_next[s + 4] = pam2_next[2*s];
        end
        rd_int_next[8] = pam3_next[7];
        wr_int_next[8] = pam3_next[6];
        rd_int_next[9] = pam3_next[5];
        wr_int_next[9] = pam3_next[4];
    end

    nbcss_ram #(
        .WIDTH(8),
        .DEPTH(nbcss_pkg::CFG_DEPTH)
    ) u_cfg_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (s_data.reg_addr),
        .wdata (s_data.wdata),
        .re    (accept),
        .raddr (s_data.reg_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= nbcss_pkg::RST_CMD;
            status_reg     <= nbcss_pkg::RST_STATUS;
            pam1_reg       <= 8'h00;
            pam2_reg       <= 8'h00;
            pam3_reg       <= 8'h00;
            ctl65_reg      <= 8'h00;
            ctl66_reg      <= 8'h00;
            ctl67_reg      <= 8'h00;
            ctl68_reg      <= 8'h00;
            ctl6d_reg      <= 8'h00;
            ctl70_reg      <= 8'h00;
            ctl71_reg      <= 8'h00;
            ctl73_reg      <= 8'h00;
            ctl75_reg      <= 8'h00;
            byte_valid_reg <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            pam1_reg   <= pam1_next;
            pam2_reg   <= pam2_next;
            pam3_reg   <= pam3_next;
            ctl65_reg  <= ctl65_next;
            ctl66_reg  <= ctl66_next;
            ctl67_reg  <= ctl67_next;
            ctl68_reg  <= ctl68_next;
            ctl6d_reg  <= ctl6d_next;
            ctl70_reg  <= ctl70_next;
            ctl71_reg  <= ctl71_next;
            ctl73_reg  <= ctl73_next;
            ctl75_reg  <= ctl75_next;
            if (mem_we) begin
                byte_valid_reg[s_data.reg_addr] <= 1'b1;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg       <= s_data.req_type;
            s1_func0_reg     <= (s_data.func_num == 3'd0);
            s1_flop_hit_reg  <= flop_hit;
            s1_flop_data_reg <= flop_rd;
            s1_mem_valid_reg <= byte_valid_reg[s_data.reg_addr];
            s1_addr_reg      <= s_data.reg_addr;
            s1_rd_int_reg    <= rd_int_next;
            s1_wr_int_reg    <= wr_int_next;
            s1_shadow_reg    <= pam3_next[5];
            s1_remap_reg     <= ({pam1_next, pam2_next, pam3_next[7:4]}
                                 != {pam1_reg, pam2_reg, pam3_reg[7:4]});
        end
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    always_comb begin
        out_next.read_internal  = s1_rd_int_reg;
        out_next.write_internal = s1_wr_int_reg;
        out_next.shadow_bios    = s1_shadow_reg;
        out_next.remap          = s1_remap_reg;
        if (s1_req_reg != nbcss_pkg::REQ_READ) begin
            out_next.rdata = 8'h00;
        end else if (!s1_func0_reg) begin
            out_next.rdata = nbcss_pkg::ABSENT_DATA;
        end else if (s1_flop_hit_reg) begin
            out_next.rdata = s1_flop_data_reg;
        end else if (s1_mem_valid_reg) begin
            out_next.rdata = ram_rdata;
        end else begin
            out_next.rdata = nbcss_pkg::reset_byte(s1_addr_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // request stage never drops a transaction while the result is stalled
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |=> s1_valid_reg)
        else $error("request stage lost a transaction under stall");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("s_ready low with room in the pipeline");

    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (s1_req_reg != nbcss_pkg::REQ_READ)) |=> (m_data_reg.rdata == 8'h00))
        else $error("nonzero read data on a non-read transaction");

    a_dev_reset_clears_f: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.req_type == nbcss_pkg::REQ_RESET)) |=>
            (pam3_reg[5:4] == 2'b00 && !s1_shadow_reg))
        else $error("device reset left the F0000 attribute set");

endmodule

// ----- tb/tb_northbridge_config_space_shadow_ctl_core.sv -----
// ----------------------------------------------------------------------------
// tb_northbridge_config_space_shadow_ctl_core: self-checking bench for the core
// Reads, writes and device resets go in through s_; an in-bench mirror of the
// 256-byte config space predicts every result, which is checked in order on m_.
// Covers read-only, masked and W1C bytes, shadow attribute decode, the remap
// pulse, absent functions and the unused request code, under random
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_northbridge_config_space_shadow_ctl_core;

    localparam int PIPE_LATENCY = 2;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 4000;

    localparam nbcss_pkg::req_t REQ_UNUSED = 2'd3;

    // Identity, class and misc header bytes (read-only except DEVICE, STATUS_LO and 0x52 upward)
    localparam logic [7:0] ADDR_VENDOR_LO  = 8'h00;
    localparam logic [7:0] ADDR_VENDOR_HI  = 8'h01;
    localparam logic [7:0] ADDR_DEVICE_LO  = 8'h02;
    localparam logic [7:0] ADDR_DEVICE_HI  = 8'h03;
    localparam logic [7:0] ADDR_STATUS_LO  = 8'h06;
    localparam logic [7:0] ADDR_REVISION   = 8'h08;
    localparam logic [7:0] ADDR_CLASS_PI   = 8'h09;
    localparam logic [7:0] ADDR_CLASS_SUB  = 8'h0A;
    localparam logic [7:0] ADDR_CLASS_BASE = 8'h0B;
    localparam logic [7:0] ADDR_CACHE_LINE = 8'h0C;
    localparam logic [7:0] ADDR_HDR_TYPE   = 8'h0E;
    localparam logic [7:0] ADDR_BIST       = 8'h0F;
    localparam logic [7:0] ADDR_CTL52      = 8'h52;
    localparam logic [7:0] ADDR_CTL58      = 8'h58;
    localparam logic [7:0] ADDR_CTL59      = 8'h59;
    localparam logic [7:0] ADDR_DRB_FIRST  = 8'h5A;
    localparam logic [7:0] ADDR_DRB_LAST   = 8'h5F;
    localparam logic [7:0] ADDR_CTL64      = 8'h64;
    localparam logic [7:0] ADDR_TOP        = 8'hFF;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    nbcss_pkg::in_t  s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    nbcss_pkg::out_t m_data;

    northbridge_config_space_shadow_ctl_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    logic [7:0]      cfg_mirror [0:255];
    nbcss_pkg::out_t result_q [$];

    int n_sent     = 0;
    int n_checked  = 0;
    int n_remap    = 0;
    int n_absent   = 0;
    int err_cnt    = 0;
    int burst_left = 0;

    // receiver hold-off handshake: test toggles hold_req, receiver acks
    logic     hold_req  = 1'b0;
    logic     hold_ack  = 1'b0;
    int       hold_left = 0;
    logic [9:0] stall_phase = '0;

    // ------------------------------------------------------------------
    // config space mirror
    // ------------------------------------------------------------------
    function automatic void mirror_power_on();
        for (int i = 0; i < 256; i++) cfg_mirror[i] = 8'h00;
        cfg_mirror[ADDR_VENDOR_LO]         = 8'h06;
        cfg_mirror[ADDR_VENDOR_HI]         = 8'h11;
        cfg_mirror[ADDR_DEVICE_LO]         = 8'h95;
        cfg_mirror[ADDR_DEVICE_HI]         = 8'h15;
        cfg_mirror[nbcss_pkg::ADDR_CMD]    = nbcss_pkg::RST_CMD;
        cfg_mirror[ADDR_STATUS_LO]         = 8'hA0;
        cfg_mirror[nbcss_pkg::ADDR_STATUS] = nbcss_pkg::RST_STATUS;
        cfg_mirror[ADDR_REVISION]          = 8'h02;
        cfg_mirror[ADDR_CLASS_BASE]        = 8'h06;
        cfg_mirror[ADDR_CTL52]             = 8'h02;
        cfg_mirror[ADDR_CTL58]             = 8'h40;
        cfg_mirror[ADDR_CTL59]             = 8'h05;
        for (int i = ADDR_DRB_FIRST; i <= ADDR_DRB_LAST; i++) cfg_mirror[i] = 8'h01;
        cfg_mirror[ADDR_CTL64]             = 8'hAB;
    endfunction

    function automatic logic [23:0] pam_image();
        return {cfg_mirror[nbcss_pkg::ADDR_PAM3][7:4], cfg_mirror[nbcss_pkg::ADDR_PAM2],
                cfg_mirror[nbcss_pkg::ADDR_PAM1], 4'h0};
    endfunction

    function automatic nbcss_pkg::out_t predict_access(input nbcss_pkg::in_t req);
        nbcss_pkg::out_t res;
        logic [23:0]     pam_before;
        logic [7:0]      wmask;
        logic [1:0]      attr;
        res        = '0;
        pam_before = pam_image();
        case (req.req_type)
            nbcss_pkg::REQ_READ: begin
                res.rdata = (req.func_num == 3'd0) ? cfg_mirror[req.reg_addr]
                                                   : nbcss_pkg::ABSENT_DATA;
            end
            nbcss_pkg::REQ_WRITE: begin
                if (req.func_num == 3'd0) begin
                    wmask = 8'hFF;
                    case (req.reg_addr)
                        ADDR_VENDOR_LO, ADDR_VENDOR_HI, ADDR_REVISION, ADDR_CLASS_PI,
                        ADDR_CLASS_SUB, ADDR_CLASS_BASE, ADDR_CACHE_LINE, ADDR_HDR_TYPE,
                        ADDR_BIST:              wmask = 8'h00;
                        nbcss_pkg::ADDR_CMD:    wmask = nbcss_pkg::MASK_CMD;
                        nbcss_pkg::ADDR_STATUS: wmask = 8'h00;
                        nbcss_pkg::ADDR_CTL65:  wmask = nbcss_pkg::MASK_CTL65;
                        nbcss_pkg::ADDR_CTL66:  wmask = nbcss_pkg::MASK_CTL66;
                        nbcss_pkg::ADDR_CTL67:  wmask = nbcss_pkg::MASK_CTL67;
                        nbcss_pkg::ADDR_CTL68:  wmask = nbcss_pkg::MASK_CTL68;
                        nbcss_pkg::ADDR_CTL6D:  wmask = nbcss_pkg::MASK_CTL6D;
                        nbcss_pkg::ADDR_CTL70:  wmask = nbcss_pkg::MASK_CTL70;
                        nbcss_pkg::ADDR_CTL71:  wmask = nbcss_pkg::MASK_CTL71;
                        nbcss_pkg::ADDR_CTL73:  wmask = nbcss_pkg::MASK_CTL73;
                        nbcss_pkg::ADDR_CTL75:  wmask = nbcss_pkg::MASK_CTL75;
                        default:                wmask = 8'hFF;
                    endcase
                    cfg_mirror[req.reg_addr] = (cfg_mirror[req.reg_addr] & ~wmask)
                                             | (req.wdata & wmask);
                    // status: write one to clear
                    if (req.reg_addr == nbcss_pkg::ADDR_STATUS)
                        cfg_mirror[nbcss_pkg::ADDR_STATUS] =
                            cfg_mirror[nbcss_pkg::ADDR_STATUS] & ~(req.wdata & nbcss_pkg::MASK_W1C);
                end
            end
            nbcss_pkg::REQ_RESET:
                cfg_mirror[nbcss_pkg::ADDR_PAM3] =
                    cfg_mirror[nbcss_pkg::ADDR_PAM3] & nbcss_pkg::MASK_F_KEEP;
            default: ;
        endcase
        for (int s = 0; s < 10; s++) begin
            if (s < 4)       attr = cfg_mirror[nbcss_pkg::ADDR_PAM1][2*s +: 2];
            else if (s < 8)  attr = cfg_mirror[nbcss_pkg::ADDR_PAM2][2*(s-4) +: 2];
            else if (s == 8) attr = cfg_mirror[nbcss_pkg::ADDR_PAM3][7:6];
            else             attr = cfg_mirror[nbcss_pkg::ADDR_PAM3][5:4];
            res.read_internal[s]  = attr[1];
            res.write_internal[s] = attr[0];
        end
        res.shadow_bios = cfg_mirror[nbcss_pkg::ADDR_PAM3][5];
        res.remap       = (pam_image() != pam_before);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // prediction on s_ acceptance, in-order check on m_ acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        nbcss_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: unexpected result %h", m_data);
                end else begin
                    want = result_q.pop_front();
                    n_checked++;
                    if (m_data.remap) n_remap++;
                    if (m_data.rdata    !== want.rdata          ||
                        m_data.read_internal  !== want.read_internal  ||
                        m_data.write_internal !== want.write_internal ||
                        m_data.shadow_bios    !== want.shadow_bios    ||
                        m_data.remap          !== want.remap) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"mismatch #%0d: exp rd=%h ri=%h wi=%h sb=%b rm=%b",
                                      " got rd=%h ri=%h wi=%h sb=%b rm=%b"},
                                     n_checked, want.rdata, want.read_internal,
                                     want.write_internal, want.shadow_bios, want.remap,
                                     m_data.rdata, m_data.read_internal,
                                     m_data.write_internal, m_data.shadow_bios,
                                     m_data.remap);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type == nbcss_pkg::REQ_READ && s_data.func_num != 3'd0)
                    n_absent++;
                result_q.push_back(predict_access(s_data));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern plus on-demand long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            case (stall_phase[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= ($urandom_range(0, 2) == 0);
                default: m_ready <= (stall_phase[1:0] != 2'b11);
            endcase
        end
    end

    // watchdog: cycles without any transaction
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("[northbridge_config_space_shadow_ctl_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_req(input nbcss_pkg::in_t req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        n_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    function automatic nbcss_pkg::in_t mk_req(input nbcss_pkg::req_t t, input logic [2:0] f,
                                              input logic [7:0] a, input logic [7:0] d);
        nbcss_pkg::in_t r;
        r.req_type = t;
        r.func_num = f;
        r.reg_addr = a;
        r.wdata    = d;
        return r;
    endfunction

    function automatic logic [7:0] pick_hot_addr();
        case ($urandom_range(0, 27))
            0:  return ADDR_VENDOR_LO;
            1:  return ADDR_VENDOR_HI;
            2:  return ADDR_REVISION;
            3:  return ADDR_CLASS_PI;
            4:  return ADDR_CLASS_SUB;
            5:  return ADDR_CLASS_BASE;
            6:  return ADDR_CACHE_LINE;
            7:  return ADDR_HDR_TYPE;
            8:  return ADDR_BIST;
            9:  return nbcss_pkg::ADDR_CMD;
            10: return nbcss_pkg::ADDR_STATUS;
            11: return nbcss_pkg::ADDR_CTL65;
            12: return nbcss_pkg::ADDR_CTL66;
            13: return nbcss_pkg::ADDR_CTL67;
            14: return nbcss_pkg::ADDR_CTL68;
            15: return nbcss_pkg::ADDR_CTL6D;
            16: return nbcss_pkg::ADDR_CTL70;
            17: return nbcss_pkg::ADDR_CTL71;
            18: return nbcss_pkg::ADDR_CTL73;
            19: return nbcss_pkg::ADDR_CTL75;
            20: return nbcss_pkg::ADDR_PAM1;
            21: return nbcss_pkg::ADDR_PAM2;
            22: return nbcss_pkg::ADDR_PAM3;
            23: return ADDR_STATUS_LO;
            24: return ADDR_CTL64;
            25: return ADDR_DRB_FIRST;
            26: return ADDR_TOP;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic nbcss_pkg::in_t random_req();
        int             pick;
        nbcss_pkg::in_t r;
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.req_type = nbcss_pkg::REQ_READ;
        else if (pick < 85) r.req_type = nbcss_pkg::REQ_WRITE;
        else if (pick < 95) r.req_type = nbcss_pkg::REQ_RESET;
        else                r.req_type = REQ_UNUSED;
        r.func_num = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        r.reg_addr = ($urandom_range(0, 1) == 0) ? pick_hot_addr()
                                                 : 8'($urandom_range(0, 255));
        r.wdata    = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, ADDR_VENDOR_LO, 8'h00));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd7, ADDR_VENDOR_LO, 8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, ADDR_TOP,       8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, ADDR_VENDOR_LO, 8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, ADDR_VENDOR_LO, 8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_CMD,    8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, nbcss_pkg::ADDR_CMD,    8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_CMD,    8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_STATUS, 8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, nbcss_pkg::ADDR_STATUS, 8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_PAM1,   8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_PAM2,   8'hAA));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_PAM3,   8'hF0));
        // same value again: no remap
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_PAM3,   8'hF0));
        send_req(mk_req(nbcss_pkg::REQ_RESET, 3'd5, ADDR_TOP,               8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, nbcss_pkg::ADDR_PAM3,   8'h00));
        // absent function write is dropped
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd3, nbcss_pkg::ADDR_PAM1,   8'h00));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, nbcss_pkg::ADDR_PAM1,   8'h00));
        send_req(mk_req(REQ_UNUSED,           3'd0, nbcss_pkg::ADDR_PAM1,   8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_CTL75,  8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, nbcss_pkg::ADDR_CTL6D,  8'h00));
        send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, ADDR_TOP,               8'hFF));
        send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, ADDR_TOP,               8'h00));
    endtask

    // masked, read-only and W1C bytes: write then read back
    task automatic test_register_rules(input int pairs);
        logic [7:0] a;
        for (int i = 0; i < pairs; i++) begin
            a = pick_hot_addr();
            send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, a, 8'($urandom_range(0, 255))));
            send_req(mk_req(nbcss_pkg::REQ_READ,  3'd0, a, 8'($urandom_range(0, 255))));
        end
    endtask

    // attribute programming sequences with device resets mixed in
    task automatic test_shadow_attributes(input int steps);
        logic [7:0] a;
        for (int i = 0; i < steps; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: a = nbcss_pkg::ADDR_PAM1;
                3, 4, 5: a = nbcss_pkg::ADDR_PAM2;
                default: a = nbcss_pkg::ADDR_PAM3;
            endcase
            case ($urandom_range(0, 5))
                0:       send_req(mk_req(nbcss_pkg::REQ_RESET, 3'($urandom_range(0, 7)),
                                         8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255))));
                1:       send_req(mk_req(nbcss_pkg::REQ_READ, 3'd0, a, 8'h00));
                2:       send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'($urandom_range(1, 7)), a,
                                         8'($urandom_range(0, 255))));
                default: send_req(mk_req(nbcss_pkg::REQ_WRITE, 3'd0, a,
                                         8'($urandom_range(0, 255))));
            endcase
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_full_backpressure(input int count);
        hold_req <= ~hold_req;
        burst_left = count + 1;
        for (int i = 0; i < count; i++) send_req(random_req());
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) send_req(random_req());
    endtask

    initial begin
        mirror_power_on();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_register_rules(125);
        wait_drained();
        test_shadow_attributes(300);
        test_full_backpressure(40);
        wait_drained();
        test_random_mix(440);
        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge aclk);

        $display("Sent %0d requests (reads, writes, device resets, unused code); %0d checked,",
                 n_sent, n_checked);
        $display("%0d remap pulses, %0d absent-function reads, one long receiver hold-off.",
                 n_remap, n_absent);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("[northbridge_config_space_shadow_ctl_core] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", err_cnt, result_q.size());
            $display("[northbridge_config_space_shadow_ctl_core] ERROR");
        end
        $finish;
    end

endmodule
